// ===== hw/rtl/tpim_pkg.sv =====
// Shared types and constants for the two-particle invariant mass core.
package tpim_pkg;

	localparam int NUM_TYPES = 7;
	localparam int TYPE_W    = 3;
	localparam int MASS_W    = 20;
	localparam int MOM_W     = 24;
	localparam int MASS_OUT_W = 25;
	localparam int STATUS_W  = 2;

	// Energy radicand m^2 + |p|^2 stays below 2^48
	localparam int ERAD_W  = 48;
	localparam int E_W     = ERAD_W / 2;
	// |p1+p2|^2 and (E1+E2)^2 stay below 2^50
	localparam int PSUM_W  = MOM_W + 1;
	localparam int P2_W    = 50;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BADTYPE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_CLAMP   = 2'd2;

	typedef logic [NUM_TYPES-1:0][MASS_W-1:0] mass_tab_t;

	typedef struct packed {
		logic [TYPE_W-1:0]       type_a;
		logic signed [MOM_W-1:0] px_a;
		logic signed [MOM_W-1:0] py_a;
		logic signed [MOM_W-1:0] pz_a;
		logic [TYPE_W-1:0]       type_b;
		logic signed [MOM_W-1:0] px_b;
		logic signed [MOM_W-1:0] py_b;
		logic signed [MOM_W-1:0] pz_b;
	} in_item_t;

	typedef struct packed {
		logic [MASS_OUT_W-1:0] inv_mass;
		logic [STATUS_W-1:0]   status;
	} out_item_t;

	// Front end results handed to the square root stages
	typedef struct packed {
		logic              vld;
		logic              bad;
		logic [ERAD_W-1:0] rad_a;
		logic [ERAD_W-1:0] rad_b;
		logic [P2_W-1:0]   p2sum;
	} front_out_t;

endpackage

// ===== hw/rtl/tpim_isqrt.sv =====
// Pipelined floor square root, one result bit per stage, with side data.
module tpim_isqrt #(
	parameter int IN_W   = 48,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  logic [IN_W-1:0]     radicand,
	input  logic [SIDE_W-1:0]   side_in,
	output logic                out_vld,
	output logic [IN_W/2-1:0]   root,
	output logic [SIDE_W-1:0]   side_out
);

	localparam int OUT_W = IN_W / 2;
	localparam int RW    = OUT_W + 2;

	for (genvar k = 0; k < OUT_W; k++) begin : g_stage
		logic              cur_vld;
		logic [RW-1:0]     cur_rem;
		logic [OUT_W-1:0]  cur_rt;
		logic [IN_W-1:0]   cur_x;
		logic [SIDE_W-1:0] cur_side;
		logic [RW-1:0]     rem_sh;
		logic [RW-1:0]     trial;
		logic              ge;

		// stage registers
		logic              vld_s;
		logic [RW-1:0]     rem_s;
		logic [OUT_W-1:0]  rt_s;
		logic [IN_W-1:0]   x_s;
		logic [SIDE_W-1:0] side_s;

		if (k == 0) begin : g_first
			assign cur_vld  = in_vld;
			assign cur_rem  = '0;
			assign cur_rt   = '0;
			assign cur_x    = radicand;
			assign cur_side = side_in;
		end else begin : g_next
			assign cur_vld  = g_stage[k-1].vld_s;
			assign cur_rem  = g_stage[k-1].rem_s;
			assign cur_rt   = g_stage[k-1].rt_s;
			assign cur_x    = g_stage[k-1].x_s;
			assign cur_side = g_stage[k-1].side_s;
		end

		// bring down the next bit pair and try root*4+1
		assign rem_sh = {cur_rem[RW-3:0], cur_x[IN_W-1 -: 2]};
		assign trial  = {cur_rt, 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s <= 1'b0;
			end else begin
				vld_s <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			rem_s  <= ge ? (rem_sh - trial) : rem_sh;
			rt_s   <= {cur_rt[OUT_W-2:0], ge};
			x_s    <= {cur_x[IN_W-3:0], 2'b00};
			side_s <= cur_side;
		end
	end

	assign out_vld  = g_stage[OUT_W-1].vld_s;
	assign root     = g_stage[OUT_W-1].rt_s;
	assign side_out = g_stage[OUT_W-1].side_s;

endmodule

// ===== hw/rtl/tpim_front.sv =====
// Front end: mass lookup, squares and sums feeding the energy roots.
module tpim_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_vld,
	input  tpim_pkg::in_item_t    operands,
	input  tpim_pkg::mass_tab_t   masses,
	output tpim_pkg::front_out_t  fout
);
	import tpim_pkg::*;

	localparam int MSQ_W = 2 * MASS_W;
	// the most negative momentum squares to 2^46, so one bit beyond 2*MOM_W-2
	localparam int PSQ_W = 2 * MOM_W - 1;
	localparam int SSQ_W = 2 * PSUM_W - 1;

	logic [MASS_W-1:0] mass_a, mass_b;
	logic              bad;

	// stage 1: capture operands and look up rest masses
	logic              vld_s1, bad_s1;
	in_item_t          op_s1;
	logic [MASS_W-1:0] ma_s1, mb_s1;

	assign mass_a = (operands.type_a < TYPE_W'(NUM_TYPES)) ?
		masses[operands.type_a] : '0;
	assign mass_b = (operands.type_b < TYPE_W'(NUM_TYPES)) ?
		masses[operands.type_b] : '0;
	assign bad = (operands.type_a >= TYPE_W'(NUM_TYPES)) ||
		(operands.type_b >= TYPE_W'(NUM_TYPES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		op_s1  <= operands;
		ma_s1  <= mass_a;
		mb_s1  <= mass_b;
		bad_s1 <= bad;
	end

	// stage 2: individual squares and momentum sums
	logic signed [2*MOM_W-1:0] sxa, sya, sza, sxb, syb, szb;
	logic              vld_s2, bad_s2;
	logic [MSQ_W-1:0]  ma2_s2, mb2_s2;
	logic [PSQ_W-1:0]  xa2_s2, ya2_s2, za2_s2, xb2_s2, yb2_s2, zb2_s2;
	logic signed [PSUM_W-1:0] psx_s2, psy_s2, psz_s2;

	assign sxa = op_s1.px_a * op_s1.px_a;
	assign sya = op_s1.py_a * op_s1.py_a;
	assign sza = op_s1.pz_a * op_s1.pz_a;
	assign sxb = op_s1.px_b * op_s1.px_b;
	assign syb = op_s1.py_b * op_s1.py_b;
	assign szb = op_s1.pz_b * op_s1.pz_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		bad_s2 <= bad_s1;
		ma2_s2 <= ma_s1 * ma_s1;
		mb2_s2 <= mb_s1 * mb_s1;
		xa2_s2 <= sxa[PSQ_W-1:0];
		ya2_s2 <= sya[PSQ_W-1:0];
		za2_s2 <= sza[PSQ_W-1:0];
		xb2_s2 <= sxb[PSQ_W-1:0];
		yb2_s2 <= syb[PSQ_W-1:0];
		zb2_s2 <= szb[PSQ_W-1:0];
		psx_s2 <= PSUM_W'(op_s1.px_a) + PSUM_W'(op_s1.px_b);
		psy_s2 <= PSUM_W'(op_s1.py_a) + PSUM_W'(op_s1.py_b);
		psz_s2 <= PSUM_W'(op_s1.pz_a) + PSUM_W'(op_s1.pz_b);
	end

	// stage 3: energy radicands and squares of the summed momentum
	logic signed [2*PSUM_W-1:0] ssx, ssy, ssz;
	logic              vld_s3, bad_s3;
	logic [ERAD_W-1:0] ra_s3, rb_s3;
	logic [SSQ_W-1:0]  qx_s3, qy_s3, qz_s3;

	assign ssx = psx_s2 * psx_s2;
	assign ssy = psy_s2 * psy_s2;
	assign ssz = psz_s2 * psz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		bad_s3 <= bad_s2;
		ra_s3  <= ERAD_W'(ma2_s2) + ERAD_W'(xa2_s2) + ERAD_W'(ya2_s2) + ERAD_W'(za2_s2);
		rb_s3  <= ERAD_W'(mb2_s2) + ERAD_W'(xb2_s2) + ERAD_W'(yb2_s2) + ERAD_W'(zb2_s2);
		qx_s3  <= ssx[SSQ_W-1:0];
		qy_s3  <= ssy[SSQ_W-1:0];
		qz_s3  <= ssz[SSQ_W-1:0];
	end

	// stage 4: total momentum squared
	logic              vld_s4, bad_s4;
	logic [ERAD_W-1:0] ra_s4, rb_s4;
	logic [P2_W-1:0]   p2_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		bad_s4 <= bad_s3;
		ra_s4  <= ra_s3;
		rb_s4  <= rb_s3;
		p2_s4  <= P2_W'(qx_s3) + P2_W'(qy_s3) + P2_W'(qz_s3);
	end

	assign fout.vld   = vld_s4;
	assign fout.bad   = bad_s4;
	assign fout.rad_a = ra_s4;
	assign fout.rad_b = rb_s4;
	assign fout.p2sum = p2_s4;

endmodule

// ===== hw/rtl/two_particle_invariant_mass_core.sv =====
// Top level of the two-particle invariant mass core.
// One pair is taken in every clock cycle (busy never rises) and its result
// appears on result with done high once it has passed four front end
// stages, the 24-stage energy root, three stages for the energy sum, its
// square and the clamp, the 25-stage mass root and the output register.
// Results cannot be held off, so each is seen for one cycle only.
// Mass registers are written through the cfg channel, which is always ready;
// write them only while no pair is in flight.
module two_particle_invariant_mass_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  tpim_pkg::in_item_t  operands,
	output logic                done,
	output tpim_pkg::out_item_t result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [19:0]         cfg_data
);
	import tpim_pkg::*;

	// mass table
	mass_tab_t mass_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= '0;
		end else if (cfg_valid && cfg_ready && (cfg_index < TYPE_W'(NUM_TYPES))) begin
			mass_q[cfg_index] <= cfg_data;
		end
	end

	// front end
	front_out_t fout;

	tpim_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (start),
		.operands (operands),
		.masses   (mass_q),
		.fout     (fout)
	);

	// energy roots, both particles in lockstep
	logic            ea_vld, eb_vld;
	logic [E_W-1:0]  e_a, e_b;
	logic [P2_W-1:0] p2_e;
	logic            bad_e;

	tpim_isqrt #(.IN_W(ERAD_W), .SIDE_W(P2_W)) u_root_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (fout.vld),
		.radicand (fout.rad_a),
		.side_in  (fout.p2sum),
		.out_vld  (ea_vld),
		.root     (e_a),
		.side_out (p2_e)
	);

	tpim_isqrt #(.IN_W(ERAD_W), .SIDE_W(1)) u_root_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (fout.vld),
		.radicand (fout.rad_b),
		.side_in  (fout.bad),
		.out_vld  (eb_vld),
		.root     (e_b),
		.side_out (bad_e)
	);

	// energy sum
	logic                vld_s5, bad_s5;
	logic [E_W:0]        esum_s5;
	logic [P2_W-1:0]     p2_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= ea_vld && eb_vld;
		end
	end

	always_ff @(posedge clk) begin
		esum_s5 <= (E_W+1)'(e_a) + (E_W+1)'(e_b);
		p2_s5   <= p2_e;
		bad_s5  <= bad_e;
	end

	// square of the energy sum
	logic                vld_s6, bad_s6;
	logic [P2_W-1:0]     e2_s6, p2_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		e2_s6  <= esum_s5 * esum_s5;
		p2_s6  <= p2_s5;
		bad_s6 <= bad_s5;
	end

	// mass radicand, clamped at zero
	logic                vld_s7, bad_s7, neg_s7;
	logic [P2_W-1:0]     rad_s7;
	logic                neg;

	assign neg = (e2_s6 < p2_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		rad_s7 <= neg ? '0 : (e2_s6 - p2_s6);
		neg_s7 <= neg;
		bad_s7 <= bad_s6;
	end

	// invariant mass root
	logic                  m_vld;
	logic [P2_W/2-1:0]     m_root;
	logic [1:0]            m_flags;

	tpim_isqrt #(.IN_W(P2_W), .SIDE_W(2)) u_root_m (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s7),
		.radicand (rad_s7),
		.side_in  ({bad_s7, neg_s7}),
		.out_vld  (m_vld),
		.root     (m_root),
		.side_out (m_flags)
	);

	// output register; a bad type outranks the clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= m_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (m_flags[1]) begin
			result.inv_mass <= '0;
			result.status   <= ST_BADTYPE;
		end else if (m_flags[0]) begin
			result.inv_mass <= '0;
			result.status   <= ST_CLAMP;
		end else begin
			result.inv_mass <= MASS_OUT_W'(m_root);
			result.status   <= ST_OK;
		end
	end

endmodule
